/* rtl/bsmg_pkg.sv */
// bsmg_pkg: shared constants, codes and types of the bounded sorted set core
// used by the interfaces, the cell chain, the gap tracker and the top level
`timescale 1ns / 1ps

package bsmg_pkg;

    // set size and derived widths
    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int CAP_W     = 7;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int LIM_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [DATA_W-1:0] SIGN_FLIP = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] ALL_ONES  = {DATA_W{1'b1}};

    // item kinds
    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_RANGE = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_FEW  = 2'd2
    } status_t;

    // control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RCHECK,
        ST_INSERT,
        ST_DRAIN
    } state_t;

    // what a cell hands to its right-hand neighbour (le goes leftwards)
    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              gt;
        logic              valid;
        logic              le;
    } link_t;

    // neighbour pick of one cell for the gap update
    typedef struct packed {
        logic              pred_hit;
        logic              succ_hit;
        logic [DATA_W-1:0] pred_data;
        logic [DATA_W-1:0] succ_data;
    } pick_t;

    // inserted value and its sorted neighbours, handed to the gap tracker
    typedef struct packed {
        logic              ins;
        logic [DATA_W-1:0] val;
        logic              pred_ok;
        logic [DATA_W-1:0] pred;
        logic              succ_ok;
        logic [DATA_W-1:0] succ;
    } probe_t;

    // flipping the sign bit makes unsigned order match signed order
    function automatic logic [DATA_W-1:0] order_key(input logic [DATA_W-1:0] v);
        return v ^ SIGN_FLIP;
    endfunction

endpackage

/* rtl/bsmg_item_if.sv */
// bsmg_item_if: input channel of the bounded sorted set core
// depends on bsmg_pkg for the mode type and data width
`timescale 1ns / 1ps

interface bsmg_item_if;
    logic                                        valid;
    logic                                        ready;
    bsmg_pkg::mode_t                             mode;
    logic signed [bsmg_pkg::DATA_W-1:0]          value;
    logic signed [bsmg_pkg::DATA_W-1:0]          range_end;

    modport source (output valid, mode, value, range_end, input ready);
    modport sink   (input valid, mode, value, range_end, output ready);
endinterface

/* rtl/bsmg_result_if.sv */
// bsmg_result_if: result channel of the bounded sorted set core
// depends on bsmg_pkg for the status type and data width
`timescale 1ns / 1ps

interface bsmg_result_if;
    logic                           valid;
    logic                           ready;
    bsmg_pkg::status_t              status;
    logic [bsmg_pkg::DATA_W-1:0]    shortest_span;
    logic [bsmg_pkg::DATA_W-1:0]    longest_span;

    modport source (output valid, status, shortest_span, longest_span, input ready);
    modport sink   (input valid, status, shortest_span, longest_span, output ready);
endinterface

/* rtl/bsmg_cell.sv */
// bsmg_cell: one slot of the sorted insertion chain
// depends on bsmg_pkg for link_t, pick_t and order_key
`timescale 1ns / 1ps

module bsmg_cell (
    input  logic                          clk,
    input  logic                          ins,
    input  logic [bsmg_pkg::DATA_W-1:0]   ins_val,
    input  logic [bsmg_pkg::DATA_W-1:0]   ins_key,
    input  logic                          valid,
    input  bsmg_pkg::link_t               left,
    input  logic                          right_le,
    output bsmg_pkg::link_t               link,
    output bsmg_pkg::pick_t               pick
);
    import bsmg_pkg::*;

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;
    logic              gt;
    logic              new_slot;

    // compare the held value with the value being inserted
    assign gt       = valid && (order_key(val_reg) > ins_key);
    assign new_slot = !valid && left.valid;

    // shift right from the left neighbour, take the new value, or hold
    always_comb
    begin
        val_next = val_reg;
        if (ins)
        begin
            if (left.gt)
                val_next = left.val;
            else if (gt || new_slot)
                val_next = ins_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    // link to the neighbours
    assign link.val   = val_reg;
    assign link.gt    = gt;
    assign link.valid = valid;
    assign link.le    = valid && !gt;

    // this cell is the predecessor or successor of the insertion point
    assign pick.pred_hit  = valid && !gt && !right_le;
    assign pick.succ_hit  = gt && !left.gt;
    assign pick.pred_data = pick.pred_hit ? val_reg : '0;
    assign pick.succ_data = pick.succ_hit ? val_reg : '0;

endmodule

/* rtl/bsmg_gap.sv */
// bsmg_gap: one-stage tracker of the smallest adjacent gap
// depends on bsmg_pkg for probe_t and constants
`timescale 1ns / 1ps

module bsmg_gap (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bsmg_pkg::probe_t              probe,
    output logic [bsmg_pkg::DATA_W-1:0]   least_gap
);
    import bsmg_pkg::*;

    logic              pend_reg;
    logic [DATA_W-1:0] val_reg;
    logic              pred_ok_reg;
    logic [DATA_W-1:0] pred_reg;
    logic              succ_ok_reg;
    logic [DATA_W-1:0] succ_reg;
    logic [DATA_W-1:0] least_reg;
    logic [DATA_W-1:0] least_next;
    logic [DATA_W-1:0] gap_lo;
    logic [DATA_W-1:0] gap_hi;
    logic [DATA_W-1:0] gap_min;

    // capture the inserted value and its neighbours
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else
            pend_reg <= probe.ins;
    end

    always_ff @(posedge clk)
    begin
        val_reg     <= probe.val;
        pred_ok_reg <= probe.pred_ok;
        pred_reg    <= probe.pred;
        succ_ok_reg <= probe.succ_ok;
        succ_reg    <= probe.succ;
    end

    // gaps on both sides of the new value, then fold into the running minimum
    always_comb
    begin
        gap_lo     = pred_ok_reg ? (val_reg - pred_reg) : ALL_ONES;
        gap_hi     = succ_ok_reg ? (succ_reg - val_reg) : ALL_ONES;
        gap_min    = (gap_lo < gap_hi) ? gap_lo : gap_hi;
        least_next = least_reg;
        if (pend_reg && (gap_min < least_reg))
            least_next = gap_min;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            least_reg <= ALL_ONES;
        else
            least_reg <= least_next;
    end

    assign least_gap = least_reg;

endmodule

/* rtl/bounded_set_min_gap_and_range_core.sv */
// Bounded sorted multiset of signed 32-bit values that reports its shortest and longest span.
// Values live in a chain of 64 cells kept in ascending order: an insert compares every cell
// against the new value and the cells above the insertion point shift right. A registered
// tracker stage then folds in the smallest adjacent gap. An add passes chain insert and gap
// update; a range end ordering, fit check, one insert per value and gap update; a query, a
// no-op and a rejected add answer from idle, a rejected range from the fit check. One word
// is in flight at a time; the next is accepted once the result register is free or being
// taken. The capacity register is written through cfg_we / cfg_wdata; the user must write
// it only while the block is idle, which the block itself does not enforce. Depends on
// bsmg_pkg, bsmg_item_if, bsmg_result_if, bsmg_cell and bsmg_gap.
`timescale 1ns / 1ps

module bounded_set_min_gap_and_range_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bsmg_pkg::CAP_W-1:0]    cfg_wdata,
    bsmg_item_if.sink                     item,
    bsmg_result_if.source                 result
);
    import bsmg_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [CAP_W-1:0]   cap_reg;
    logic [CNT_W-1:0]   held_reg;
    logic [CNT_W-1:0]   held_next;
    logic [DATA_W-1:0]  max_reg;
    logic [DATA_W-1:0]  max_next;
    logic [DATA_W-1:0]  lo_reg;
    logic [DATA_W-1:0]  lo_next;
    logic [DATA_W-1:0]  hi_reg;
    logic [DATA_W-1:0]  hi_next;
    logic [DATA_W-1:0]  cur_reg;
    logic [DATA_W-1:0]  cur_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    status_t            out_status_reg;
    status_t            out_status_next;
    logic [DATA_W-1:0]  out_short_reg;
    logic [DATA_W-1:0]  out_short_next;
    logic [DATA_W-1:0]  out_long_reg;
    logic [DATA_W-1:0]  out_long_next;

    logic               accept;
    logic               do_ins;
    logic [DATA_W-1:0]  ins_val;
    logic [DATA_W-1:0]  ins_key;
    logic [LIM_W-1:0]   cap_ext;
    logic [LIM_W-1:0]   held_ext;
    logic [LIM_W-1:0]   limit;
    logic [LIM_W-1:0]   free_slots;
    logic [DATA_W-1:0]  key_a;
    logic [DATA_W-1:0]  key_b;
    logic [DATA_W-1:0]  span;
    logic               fits;
    logic [DATA_W-1:0]  least_gap;

    logic [MAX_ITEMS-1:0] cell_valid;
    link_t                links [MAX_ITEMS];
    pick_t                picks [MAX_ITEMS];
    link_t                head_link;
    probe_t               probe;

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= '0;
        else if (cfg_we)
            cap_reg <= cfg_wdata;
    end

    // free space, with the limit saturating at the chain length
    always_comb
    begin
        cap_ext    = LIM_W'(cap_reg);
        held_ext   = LIM_W'(held_reg);
        limit      = (cap_ext > LIM_W'(MAX_ITEMS)) ? LIM_W'(MAX_ITEMS) : cap_ext;
        free_slots = (held_ext < limit) ? (limit - held_ext) : '0;
    end

    // handshake
    assign item.ready = (state_reg == ST_IDLE) && (!out_valid_reg || result.ready);
    assign accept     = item.valid && item.ready;

    // value entering the chain this cycle
    assign ins_val = (state_reg == ST_INSERT) ? order_key(cur_reg) : item.value;
    assign ins_key = order_key(ins_val);

    // range ends as order keys, and the fit check on the ordered ends
    assign key_a = order_key(item.value);
    assign key_b = order_key(item.range_end);
    assign span  = hi_reg - lo_reg;
    assign fits  = (free_slots != '0) && (span < DATA_W'(free_slots));

    // sequencer: next state, chain insert strobe and result loading
    always_comb
    begin
        state_next      = state_reg;
        do_ins          = 1'b0;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        cur_next        = cur_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_status_next = out_status_reg;
        out_short_next  = out_short_reg;
        out_long_next   = out_long_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.mode)
                        MODE_ADD:
                        begin
                            if (free_slots != '0)
                            begin
                                do_ins     = 1'b1;
                                state_next = ST_DRAIN;
                            end
                            else
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = STATUS_FULL;
                                out_short_next  = '0;
                                out_long_next   = '0;
                            end
                        end
                        MODE_RANGE:
                        begin
                            lo_next    = (key_b < key_a) ? key_b : key_a;
                            hi_next    = (key_b < key_a) ? key_a : key_b;
                            state_next = ST_RCHECK;
                        end
                        MODE_QUERY:
                        begin
                            out_valid_next = 1'b1;
                            if (held_reg < CNT_W'(2))
                            begin
                                out_status_next = STATUS_FEW;
                                out_short_next  = '0;
                                out_long_next   = '0;
                            end
                            else
                            begin
                                out_status_next = STATUS_OK;
                                out_short_next  = least_gap;
                                out_long_next   = max_reg - links[0].val;
                            end
                        end
                        default:
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = STATUS_OK;
                            out_short_next  = '0;
                            out_long_next   = '0;
                        end
                    endcase
                end
            end
            ST_RCHECK:
            begin
                if (fits)
                begin
                    cur_next   = lo_reg;
                    state_next = ST_INSERT;
                end
                else
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STATUS_FULL;
                    out_short_next  = '0;
                    out_long_next   = '0;
                    state_next      = ST_IDLE;
                end
            end
            ST_INSERT:
            begin
                do_ins = 1'b1;
                if (cur_reg == hi_reg)
                    state_next = ST_DRAIN;
                else
                    cur_next = cur_reg + DATA_W'(1);
            end
            ST_DRAIN:
            begin
                out_valid_next  = 1'b1;
                out_status_next = STATUS_OK;
                out_short_next  = '0;
                out_long_next   = '0;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // count and running maximum follow each insert
    always_comb
    begin
        held_next = held_reg;
        max_next  = max_reg;
        if (do_ins)
        begin
            held_next = held_reg + CNT_W'(1);
            if ((held_reg == '0) || (ins_key > order_key(max_reg)))
                max_next = ins_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        max_reg        <= max_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        cur_reg        <= cur_next;
        out_status_reg <= out_status_next;
        out_short_reg  <= out_short_next;
        out_long_reg   <= out_long_next;
    end

    // the chain of cells, occupied from the left by the held count
    assign head_link.val   = '0;
    assign head_link.gt    = 1'b0;
    assign head_link.valid = 1'b1;
    assign head_link.le    = 1'b0;

    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        link_t left_link;
        logic  right_le;

        assign cell_valid[i] = held_reg > CNT_W'(i);

        if (i == 0)
        begin : g_head
            assign left_link = head_link;
        end
        else
        begin : g_body
            assign left_link = links[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_tail
            assign right_le = 1'b0;
        end
        else
        begin : g_mid
            assign right_le = links[i+1].le;
        end

        bsmg_cell u_cell (
            .clk      (clk),
            .ins      (do_ins),
            .ins_val  (ins_val),
            .ins_key  (ins_key),
            .valid    (cell_valid[i]),
            .left     (left_link),
            .right_le (right_le),
            .link     (links[i]),
            .pick     (picks[i])
        );
    end

    // gather the neighbours of the insertion point
    always_comb
    begin
        probe.ins     = do_ins;
        probe.val     = ins_val;
        probe.pred_ok = 1'b0;
        probe.pred    = '0;
        probe.succ_ok = 1'b0;
        probe.succ    = '0;
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            probe.pred_ok = probe.pred_ok | picks[i].pred_hit;
            probe.pred    = probe.pred | picks[i].pred_data;
            probe.succ_ok = probe.succ_ok | picks[i].succ_hit;
            probe.succ    = probe.succ | picks[i].succ_data;
        end
    end

    bsmg_gap u_gap (
        .clk       (clk),
        .rst_n     (rst_n),
        .probe     (probe),
        .least_gap (least_gap)
    );

    // result register
    assign result.valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.shortest_span = out_short_reg;
    assign result.longest_span  = out_long_reg;

endmodule

/* tb/bounded_set_min_gap_and_range_core_checker.sv */
// bounded_set_min_gap_and_range_core_checker: watches the item, result and config ports,
// keeps its own sorted set, predicts each result word and compares it field by field
// depends on bsmg_pkg, bsmg_item_if and bsmg_result_if
`timescale 1ns / 1ps

module bounded_set_min_gap_and_range_core_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bsmg_pkg::CAP_W-1:0]    cfg_wdata,
    bsmg_item_if                          item_mon,
    bsmg_result_if                        result_mon,
    output int unsigned                   mismatches,
    output int unsigned                   outstanding
);
    import bsmg_pkg::*;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] shortest;
        logic [DATA_W-1:0] longest;
    } span_report_t;

    // predicted set contents and settings
    logic [DATA_W-1:0] held_vals [MAX_ITEMS];
    int unsigned       held_n;
    logic [DATA_W-1:0] min_gap;
    logic [CAP_W-1:0]  cap_reg;
    int unsigned       error_count;

    span_report_t span_reports [$];

    // free slots left under the saturated capacity
    function automatic int unsigned free_room();
        int unsigned limit;
        limit = (cap_reg > MAX_ITEMS) ? MAX_ITEMS : cap_reg;
        return (held_n < limit) ? limit - held_n : 0;
    endfunction

    // sorted insert, folding both new neighbour gaps into the running minimum
    function automatic void place_value(input logic [DATA_W-1:0] v);
        int unsigned       slot;
        logic [DATA_W-1:0] diff;
        slot = held_n;
        while (slot > 0 && $signed(held_vals[slot-1]) > $signed(v))
        begin
            held_vals[slot] = held_vals[slot-1];
            slot--;
        end
        held_vals[slot] = v;
        if (slot > 0)
        begin
            diff = v - held_vals[slot-1];
            if (diff < min_gap)
                min_gap = diff;
        end
        if (slot < held_n)
        begin
            diff = held_vals[slot+1] - v;
            if (diff < min_gap)
                min_gap = diff;
        end
        held_n++;
    endfunction

    // applies one input word to the set and returns the result it should give
    function automatic span_report_t apply_word(input mode_t mode,
                                                input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
        span_report_t rep;
        longint       lo;
        longint       hi;
        longint       tmp;
        rep = '{status: STATUS_OK, shortest: '0, longest: '0};
        case (mode)
            MODE_ADD:
            begin
                if (free_room() > 0)
                    place_value(a);
                else
                    rep.status = STATUS_FULL;
            end
            MODE_RANGE:
            begin
                lo = longint'($signed(a));
                hi = longint'($signed(b));
                if (hi < lo)
                begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
                if (hi - lo + 1 <= longint'(free_room()))
                begin
                    for (longint k = lo; k <= hi; k++)
                        place_value(k[DATA_W-1:0]);
                end
                else
                    rep.status = STATUS_FULL;
            end
            MODE_QUERY:
            begin
                if (held_n < 2)
                    rep.status = STATUS_FEW;
                else
                begin
                    rep.shortest = min_gap;
                    rep.longest  = held_vals[held_n-1] - held_vals[0];
                end
            end
            default: ;
        endcase
        return rep;
    endfunction

    // result check first, then config, then the newly accepted word
    always @(posedge clk or negedge rst_n)
    begin
        span_report_t want;
        if (!rst_n)
        begin
            held_n      = 0;
            min_gap     = '1;
            cap_reg     = '0;
            error_count = 0;
            span_reports.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (result_mon.valid && result_mon.ready)
            begin
                if (span_reports.size() == 0)
                begin
                    $error("result word with no word outstanding: status %0d",
                           result_mon.status);
                    error_count++;
                end
                else
                begin
                    want = span_reports.pop_front();
                    if (result_mon.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               want.status, result_mon.status);
                        error_count++;
                    end
                    if (result_mon.shortest_span !== want.shortest)
                    begin
                        $error("shortest_span: expected %h, actual %h",
                               want.shortest, result_mon.shortest_span);
                        error_count++;
                    end
                    if (result_mon.longest_span !== want.longest)
                    begin
                        $error("longest_span: expected %h, actual %h",
                               want.longest, result_mon.longest_span);
                        error_count++;
                    end
                end
            end
            if (cfg_we)
                cap_reg = cfg_wdata;
            if (item_mon.valid && item_mon.ready)
                span_reports.insert(span_reports.size(),
                                    apply_word(item_mon.mode, item_mon.value,
                                               item_mon.range_end));
            mismatches  <= error_count;
            outstanding <= span_reports.size();
        end
    end

endmodule

/* tb/bounded_set_min_gap_and_range_core_tb.sv */
// bounded_set_min_gap_and_range_core_tb: clock, reset, stimulus and verdict for the set core
// drives directed then random words through capacity phases; checking is in the checker module
// depends on bsmg_pkg, bsmg_item_if, bsmg_result_if and bounded_set_min_gap_and_range_core_checker
`timescale 1ns / 1ps

module bounded_set_min_gap_and_range_core_tb;
    import bsmg_pkg::*;

    localparam int NUM_PHASES      = 20;
    localparam int WORDS_PER_PHASE = 72;
    localparam int LATE_PHASE      = 11;
    localparam int HOLD_PHASE      = 5;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int TAIL_CYCLES     = 80;
    localparam int CYCLE_LIMIT     = 1000000;

    // capacity per random phase: slow growth with an early drop, saturation, then drops below the fill level
    localparam int CAP_PLAN [NUM_PHASES] = '{3, 1, 5, 8, 11, 15, 20, 26, 33, 40,
                                             47, 54, 60, 64, 65, 100, 127, 0, 64, 2};

    localparam logic [DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CAP_W-1:0]  cfg_wdata;
    int unsigned       mismatches;
    int unsigned       outstanding;
    int unsigned       cycle_count;
    bit                no_gaps;
    bit                hold_off_req;
    logic [DATA_W-1:0] last_added;

    bsmg_item_if   item_ch ();
    bsmg_result_if result_ch ();

    bounded_set_min_gap_and_range_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (result_ch)
    );

    bounded_set_min_gap_and_range_core_checker span_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .item_mon    (item_ch),
        .result_mon  (result_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("bounded_set_min_gap_and_range_core_tb failed");
                $finish;
            end
        end
    end

    // result side: random stalls per word, one long hold-off on request
    initial
    begin : result_taker
        int unsigned pause;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                pause        = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            else
                pause = no_gaps ? 0 : $urandom_range(0, 15);
            if (pause != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
        end
    end

    // offers one word after a random gap and returns at the edge it is taken
    task automatic send_word(input mode_t mode, input logic [DATA_W-1:0] a,
                             input logic [DATA_W-1:0] b);
        int unsigned pause;
        pause = no_gaps ? 0 : $urandom_range(0, 15);
        if (pause != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.mode      <= mode;
        item_ch.value     <= a;
        item_ch.range_end <= b;
        do @(posedge clk); while (!(item_ch.valid && item_ch.ready));
    endtask

    // stops offering and waits for every predicted word to come back
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_capacity(input int cap);
        cfg_wdata <= cap[CAP_W-1:0];
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // random word: late phases favour short ranges and near-duplicates to close the gap
    task automatic send_random_word(input bit late);
        int unsigned       pick;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] span;
        pick = $urandom_range(0, 99);
        a    = $urandom;
        b    = $urandom;
        if (pick < 35)
        begin
            if (late && $urandom_range(0, 3) == 0)
                a = last_added + $urandom_range(0, 1);
            else if ($urandom_range(0, 7) == 0)
                a = $urandom_range(0, 2000) - 1000;
            last_added = a;
            send_word(MODE_ADD, a, b);
        end
        else if (pick < 60)
        begin
            if (late && $urandom_range(0, 3) != 0)
                span = $urandom_range(0, 3);
            else
                span = $urandom_range(0, 1) ? 0 : $urandom;
            b = a + span;
            if ($urandom_range(0, 1))
                send_word(MODE_RANGE, b, a);
            else
                send_word(MODE_RANGE, a, b);
        end
        else if (pick < 90)
            send_word(MODE_QUERY, a, b);
        else
            send_word(MODE_NOP, a, b);
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        item_ch.valid     = 1'b0;
        item_ch.mode      = MODE_NOP;
        item_ch.value     = '0;
        item_ch.range_end = '0;
        no_gaps           = 1'b0;
        hold_off_req      = 1'b0;
        last_added        = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero capacity: every insert is refused, queries see too few values
        write_capacity(0);
        send_word(MODE_ADD, 32'd5, 32'd0);
        send_word(MODE_RANGE, 32'd1, 32'd1);
        send_word(MODE_QUERY, '0, '0);
        send_word(MODE_NOP, '1, '1);
        drain_results();

        // two slots: the extremes give the widest spans, then the set is full
        write_capacity(2);
        send_word(MODE_QUERY, '1, '1);
        send_word(MODE_ADD, INT_MAX, '0);
        send_word(MODE_QUERY, '0, '0);
        send_word(MODE_ADD, INT_MIN, '1);
        send_word(MODE_QUERY, '0, '0);
        send_word(MODE_ADD, 32'd0, '0);
        send_word(MODE_RANGE, 32'd7, 32'd7);
        drain_results();

        // capacity above the cell count saturates; whole-width ranges never fit
        write_capacity(127);
        send_word(MODE_RANGE, INT_MIN, INT_MAX);
        send_word(MODE_RANGE, INT_MAX, INT_MIN);
        send_word(MODE_RANGE, 32'h2000_0000, 32'h2000_0000);
        send_word(MODE_ADD, 32'h4000_0000, '0);
        send_word(MODE_ADD, 32'hC000_0000, '0);
        send_word(MODE_QUERY, '0, '0);
        send_word(MODE_NOP, '0, '0);
        drain_results();

        // capacity below the fill level: no free room at all
        write_capacity(1);
        send_word(MODE_ADD, 32'd3, '0);
        send_word(MODE_RANGE, 32'd3, 32'd3);
        send_word(MODE_QUERY, '0, '0);
        drain_results();

        // random phases, each at its own capacity
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            write_capacity(CAP_PLAN[phase]);
            no_gaps = (phase % 4 == 2);
            if (phase == HOLD_PHASE)
                hold_off_req = 1'b1;
            repeat (WORDS_PER_PHASE) send_random_word(phase >= LATE_PHASE);
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("bounded_set_min_gap_and_range_core_tb passed");
        else
            $display("bounded_set_min_gap_and_range_core_tb failed");
        $finish;
    end

endmodule
